// File: sv/rglg_pkg.sv
// ----------------------------------------------------------------------------
// rglg_pkg
// Shared constants, types and the gamma factor table builder.
// ----------------------------------------------------------------------------
package rglg_pkg;

    localparam int FACTOR_FRACTION_BITS = 16;
    localparam int FACTOR_INT_BITS      = 4;   // 2.55^2.5 < 16
    localparam int INTERNAL_BITS        = 28;
    localparam int EXP_BITS             = 20;

    localparam logic [31:0] GAMMA_RED_Q20   = 32'd1835008;
    localparam logic [31:0] GAMMA_GREEN_Q20 = 32'd2411725;
    localparam logic [31:0] GAMMA_BLUE_Q20  = 32'd2621440;

    localparam int NUM_CH    = 3;
    localparam int CHAN_W    = 8;
    localparam int LEVEL_W   = 8;
    localparam int SUM_W     = 10;
    localparam int CM_W      = 16;
    localparam int DIV_W     = 20;
    localparam int QUO_W     = 9;
    localparam int NUM_CELLS = QUO_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_RED_MAX   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_MAX  = 2'd2;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RESET = 8'd30;
    localparam logic [LEVEL_W-1:0] LEVEL_SAT       = 8'd255;

    // data handed from cell to cell of the divider row
    typedef struct packed {
        logic [NUM_CH-1:0][DIV_W-1:0] rem;
        logic [NUM_CH-1:0][QUO_W-1:0] quo;
        logic [SUM_W-1:0]             sum;
    } t_div_word;

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bit_v;
        logic [63:0] rem;
        res   = 64'd0;
        bit_v = 64'd1 << 62;
        rem   = n;
        for (int i = 0; i < 32; i++) begin
            if (bit_v > rem) begin
                bit_v = bit_v >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (bit_v != 64'd0) begin
                if (rem >= res + bit_v) begin
                    rem = rem - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] fixed_pow(input logic [63:0] x, input logic [31:0] e);
        logic [63:0] acc;
        logic [63:0] r;
        logic [31:0] whole;
        acc   = 64'd1 << INTERNAL_BITS;
        r     = x;
        whole = e >> EXP_BITS;
        for (int i = 0; i < 4; i++) begin
            if (32'(i) < whole) begin
                acc = (acc * x) >> INTERNAL_BITS;
            end
        end
        for (int i = 1; i <= EXP_BITS; i++) begin
            r = int_sqrt(r << INTERNAL_BITS);
            if (e[EXP_BITS-i]) begin
                acc = (acc * r) >> INTERNAL_BITS;
            end
        end
        return acc;
    endfunction

    // gamma factor for one alpha code, elaborated into a constant table
    function automatic logic [63:0] gamma_factor(input int a, input logic [31:0] e,
                                                 input int frac);
        logic [63:0] x;
        x = (64'(a) << INTERNAL_BITS) / 64'd100;
        return fixed_pow(x, e) >> (INTERNAL_BITS - frac);
    endfunction

endpackage

// File: sv/rglg_ifs.sv
// ----------------------------------------------------------------------------
// rglg channel interfaces
// Valid/ready channels for color words, drive levels and register writes.
// ----------------------------------------------------------------------------
interface rglg_color_if;
    logic        valid;
    logic        ready;
    logic [31:0] color_code;
    modport source (output valid, output color_code, input ready);
    modport sink   (input valid, input color_code, output ready);
endinterface

interface rglg_level_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    modport source (output valid, output red_level, output green_level, output blue_level,
                    input ready);
    modport sink   (input valid, input red_level, input green_level, input blue_level,
                    output ready);
endinterface

interface rglg_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/rglg_scale.sv
// ----------------------------------------------------------------------------
// rglg_scale
// Two-stage front end: factor lookup and C*max, then times factor.
// ----------------------------------------------------------------------------
module rglg_scale #(
    parameter int FACTOR_FRACTION_BITS = rglg_pkg::FACTOR_FRACTION_BITS
) (
    input  logic                                                    i_clk,
    input  logic                                                    i_rst_n,
    input  logic                                                    i_valid,
    output logic                                                    o_ready,
    input  logic [31:0]                                             i_color_code,
    input  logic [rglg_pkg::NUM_CH-1:0][rglg_pkg::LEVEL_W-1:0]      i_max_level,
    output logic                                                    o_valid,
    input  logic                                                    i_ready,
    output rglg_pkg::t_div_word                                     o_word
);
    import rglg_pkg::*;

    localparam int FW = FACTOR_FRACTION_BITS + FACTOR_INT_BITS;
    localparam int PW = CM_W + FW;

    logic [FW-1:0] w_rom [NUM_CH][256];

    for (genvar c = 0; c < NUM_CH; c++) begin : g_rom_ch
        localparam logic [31:0] GAMMA_C = (c == 0) ? GAMMA_RED_Q20 :
                                          (c == 1) ? GAMMA_GREEN_Q20 : GAMMA_BLUE_Q20;
        for (genvar a = 0; a < 256; a++) begin : g_rom_ent
            assign w_rom[c][a] = FW'(gamma_factor(a, GAMMA_C, FACTOR_FRACTION_BITS));
        end
    end

    logic [NUM_CH-1:0][CHAN_W-1:0] w_chan;
    logic [7:0]                    w_alpha;
    logic [SUM_W-1:0]              w_sum;

    assign w_chan[0] = i_color_code[31:24];
    assign w_chan[1] = i_color_code[23:16];
    assign w_chan[2] = i_color_code[15:8];
    assign w_alpha   = i_color_code[7:0];
    assign w_sum     = SUM_W'(w_chan[0]) + SUM_W'(w_chan[1]) + SUM_W'(w_chan[2]);

    logic                        r_v1;
    logic [NUM_CH-1:0][CM_W-1:0] r_cm;
    logic [NUM_CH-1:0][FW-1:0]   r_f;
    logic [SUM_W-1:0]            r_sum1;
    logic                        r_v2;
    t_div_word                   r_word;
    logic                        w_rdy2;
    logic [PW-1:0]               w_prod [NUM_CH];

    assign w_rdy2  = !r_v2 || i_ready;
    assign o_ready = !r_v1 || w_rdy2;
    assign o_valid = r_v2;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_ready) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_cm[c] <= CM_W'(w_chan[c]) * CM_W'(i_max_level[c]);
                r_f[c]  <= w_rom[c][w_alpha];
            end
            // zero sum has zero numerator; divide by one to get zero
            r_sum1 <= (w_sum == '0) ? SUM_W'(1) : w_sum;
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_prod[c] = PW'(r_cm[c]) * PW'(r_f[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_word.rem[c] <= w_prod[c][FACTOR_FRACTION_BITS +: DIV_W];
                r_word.quo[c] <= '0;
            end
            r_word.sum <= r_sum1;
        end
    end

endmodule

// File: sv/rglg_div_cell.sv
// ----------------------------------------------------------------------------
// rglg_div_cell
// One restoring-division cell: settles quotient bit K for all three channels.
// ----------------------------------------------------------------------------
module rglg_div_cell #(
    parameter int K = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rglg_pkg::t_div_word i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output rglg_pkg::t_div_word o_word
);
    import rglg_pkg::*;

    logic      r_valid;
    t_div_word r_word;
    t_div_word n_word;
    logic [DIV_W-1:0] w_div;

    assign w_div   = DIV_W'(i_word.sum) << K;
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        n_word = i_word;
        for (int c = 0; c < NUM_CH; c++) begin
            if (i_word.rem[c] >= w_div) begin
                n_word.rem[c]    = i_word.rem[c] - w_div;
                n_word.quo[c][K] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

// File: sv/rgba_to_led_gamma_levels_core.sv
// ----------------------------------------------------------------------------
// rgba_to_led_gamma_levels_core
// RGBA word to gamma-corrected LED drive levels, fully pipelined.
// ----------------------------------------------------------------------------
// Channels: i_color takes one packed RGBA word per transfer, o_level gives
// red/green/blue drive levels, i_cfg writes the three full-scale levels
// (index 0 red, 1 green, 2 blue; index 3 is ignored). i_cfg.ready is always
// high; write registers only while no pixel is in flight.
// Each level = floor(C * max * gamma(A) / (S * 2^F)), saturated to 255, and
// zero when A or S is zero.
// On its way from input transfer to result valid the word passes twelve
// registers: two stages for the table lookup and the two multiplies, nine
// divider cells (one quotient bit each, the top one flags saturation) and
// the output register; the first of them loads at the input transfer.
// Throughput is one word per cycle. Every stage has its own valid bit and
// takes data whenever it is empty or moving, so a stalled receiver only
// stops the pipeline once bubbles have been squeezed out.
// Reset clears all valid bits and loads 30 into the full-scale registers.
// ----------------------------------------------------------------------------
module rgba_to_led_gamma_levels_core #(
    parameter int FACTOR_FRACTION_BITS = rglg_pkg::FACTOR_FRACTION_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rglg_cfg_if.sink          i_cfg,
    rglg_color_if.sink        i_color,
    rglg_level_if.source      o_level
);
    import rglg_pkg::*;

    logic [NUM_CH-1:0][LEVEL_W-1:0] r_max_level;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_level <= {NUM_CH{MAX_LEVEL_RESET}};
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_RED_MAX:   r_max_level[0] <= i_cfg.data;
                REG_GREEN_MAX: r_max_level[1] <= i_cfg.data;
                REG_BLUE_MAX:  r_max_level[2] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    logic      w_valid [NUM_CELLS+1];
    logic      w_ready [NUM_CELLS+1];
    t_div_word w_word  [NUM_CELLS+1];

    rglg_scale #(
        .FACTOR_FRACTION_BITS(FACTOR_FRACTION_BITS)
    ) u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_color.valid),
        .o_ready      (i_color.ready),
        .i_color_code (i_color.color_code),
        .i_max_level  (r_max_level),
        .o_valid      (w_valid[0]),
        .i_ready      (w_ready[0]),
        .o_word       (w_word[0])
    );

    for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
        rglg_div_cell #(
            .K(NUM_CELLS - 1 - j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[j]),
            .o_ready (w_ready[j]),
            .i_word  (w_word[j]),
            .o_valid (w_valid[j+1]),
            .i_ready (w_ready[j+1]),
            .o_word  (w_word[j+1])
        );
    end

    // output register
    logic                           r_out_valid;
    logic [NUM_CH-1:0][LEVEL_W-1:0] r_level;
    t_div_word                      w_last;

    assign w_last              = w_word[NUM_CELLS];
    assign w_ready[NUM_CELLS]  = !r_out_valid || o_level.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[NUM_CELLS]) begin
            r_out_valid <= w_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[NUM_CELLS] && w_valid[NUM_CELLS]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_level[c] <= w_last.quo[c][QUO_W-1] ? LEVEL_SAT
                                                     : w_last.quo[c][LEVEL_W-1:0];
            end
        end
    end

    assign o_level.valid       = r_out_valid;
    assign o_level.red_level   = r_level[0];
    assign o_level.green_level = r_level[1];
    assign o_level.blue_level  = r_level[2];

endmodule

// File: sv/rglg_checker.sv
// ----------------------------------------------------------------------------
// rglg_checker
// Port-level checks: occupancy bound, no invented results, stall behavior, config ready.
// ----------------------------------------------------------------------------
module rglg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_red,
    input logic [7:0] i_green,
    input logic [7:0] i_blue,
    input logic       i_cfg_ready
);
    localparam int DEPTH = 12;

    logic [3:0] r_cnt;
    logic       w_in_xfer;
    logic       w_out_xfer;

    assign w_in_xfer  = i_in_valid && i_in_ready;
    assign w_out_xfer = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 4'(w_in_xfer) - 4'(w_out_xfer);
        end
    end

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'(DEPTH))
        else $error("more words in flight than pipeline stages");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != 4'd0)
        else $error("result valid with no word in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_red) && $stable(i_green) && $stable(i_blue))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind rgba_to_led_gamma_levels_core rglg_checker u_rglg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_color.valid),
    .i_in_ready  (i_color.ready),
    .i_out_valid (o_level.valid),
    .i_out_ready (o_level.ready),
    .i_red       (o_level.red_level),
    .i_green     (o_level.green_level),
    .i_blue      (o_level.blue_level),
    .i_cfg_ready (i_cfg.ready)
);
